[hw/rtl/mrrh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex round-robin handoff package
// Shared types and constants for the hardware mutex with waiter handoff.
// ----------------------------------------------------------------------------
package mrrh_pkg;

	localparam int MAX_TASKS = 32;

	localparam int IN_BITS = 41;
	localparam int IN_BYTES_BITS = 48;
	localparam int OUT_BITS = 15;
	localparam int OUT_BYTES_BITS = 16;

	typedef enum logic [1:0] {
		ACT_LOCK   = 2'd0,
		ACT_UNLOCK = 2'd1,
		ACT_INIT   = 2'd2,
		ACT_RSVD   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_INIT  = 3'd1,
		ST_BAD_CTX   = 3'd2,
		ST_RECURSIVE = 3'd3,
		ST_IRQS_OFF  = 3'd4,
		ST_NOT_OWNER = 3'd5,
		ST_WAIT      = 3'd6
	} status_t;

	typedef enum logic {
		CFG_NUM_TASKS = 1'b0,
		CFG_IDLE_TASK = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [31:0] blocked_tasks;
		logic        irqs_were_off;
		logic        context_ok;
		logic [4:0]  requester_task;
		logic [1:0]  action;
	} req_t;

	typedef struct packed {
		logic [4:0] owner_after;
		logic       locked_after;
		logic [4:0] handoff_task;
		logic       handoff_valid;
		logic [2:0] status;
	} rsp_t;

endpackage

[hw/rtl/mutex_round_robin_handoff.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex round-robin handoff
// Hardware lock with init, lock and unlock requests and direct handoff of
// ownership to the next blocked waiter, searched round-robin after the owner.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tdata (action, requester_task, context_ok,
//   irqs_were_off, blocked_tasks) and each request yields exactly one
//   response on m_tdata (status, handoff_valid, handoff_task, locked_after,
//   owner_after). The configuration channel writes the task count (index 0)
//   and idle_task (index 1); it is always ready; the user must write it only
//   while idle, as the block does not enforce this. A request is captured in
//   the input register and resolved by one pass of logic, a split at the
//   requester and find-first over the 32-bit waiting mask, into the output
//   register; one request per cycle is sustained while m_tready stays high.
//   When the receiver stalls, the held response stays in the output register
//   and one further request waits in the input register; s_tready then drops.
//   Reset clears the lock state and the initialized flag, sets the task count
//   to 32 and idle_task to 0, and empties both registers.
// ----------------------------------------------------------------------------
module mutex_round_robin_handoff
	import mrrh_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// action[1:0], requester_task[6:2], context_ok[7], irqs_were_off[8],
	// blocked_tasks[40:9], zero fill[47:41]
	input  logic [IN_BYTES_BITS-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[2:0], handoff_valid[3], handoff_task[8:4], locked_after[9],
	// owner_after[14:10], zero fill[15]
	output logic [OUT_BYTES_BITS-1:0] m_tdata,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [5:0]                cfg_data
);

	logic        valid_s1;
	req_t        req_s1;
	logic        m_valid_q;
	rsp_t        rsp_q;
	logic        adv;

	logic [5:0]  num_tasks_q;
	logic [4:0]  idle_q;
	logic        init_q;
	logic        held_q;
	logic [4:0]  owner_q;
	logic [31:0] wait_q;

	logic        nxt_init;
	logic        nxt_held;
	logic [4:0]  nxt_owner;
	logic [31:0] nxt_wait;
	rsp_t        rsp_d;

	logic [5:0]  eff_count;
	logic [31:0] valid_ids;
	logic [31:0] me;
	logic [31:0] above_t;
	logic [31:0] cand;
	logic [31:0] stale;
	logic [31:0] pick;
	logic [31:0] onehot;
	logic [31:0] below_f;
	logic [31:0] swept;
	logic        found;
	logic        found_hi;
	logic [4:0]  found_id;
	logic        bad_ctx;

	assign cfg_ready = 1'b1;
	assign adv = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_valid_q;
	assign m_tdata = {{(OUT_BYTES_BITS - OUT_BITS){1'b0}}, rsp_q};

	always_comb begin
		eff_count = (num_tasks_q > 6'(MAX_TASKS)) ? 6'(MAX_TASKS) : num_tasks_q;
		for (int i = 0; i < 32; i++) begin
			valid_ids[i] = (6'(i) < eff_count) && (5'(i) != idle_q);
		end
		me = 32'd1 << req_s1.requester_task;
		above_t = ~((me - 32'd1) | me);
		cand = wait_q & valid_ids & req_s1.blocked_tasks;
		stale = wait_q & valid_ids & ~req_s1.blocked_tasks;
		found_hi = |(cand & above_t);
		pick = found_hi ? (cand & above_t) : (cand & ~above_t);
		found = |pick;
		onehot = pick & (~pick + 32'd1);
		found_id = '0;
		for (int i = 0; i < 32; i++) begin
			if (onehot[i]) begin
				found_id = found_id | 5'(i);
			end
		end
		below_f = onehot - 32'd1;
		if (!found) begin
			swept = '1;
		end else if (found_hi) begin
			swept = above_t & below_f;
		end else begin
			swept = above_t | below_f;
		end
		bad_ctx = !req_s1.context_ok || (req_s1.requester_task == idle_q) ||
			({1'b0, req_s1.requester_task} >= eff_count);
	end

	always_comb begin
		nxt_init = init_q;
		nxt_held = held_q;
		nxt_owner = owner_q;
		nxt_wait = wait_q;
		rsp_d = '0;
		rsp_d.status = ST_OK;
		unique case (action_t'(req_s1.action))
			ACT_INIT: begin
				nxt_held = 1'b0;
				nxt_owner = '0;
				nxt_wait = '0;
				nxt_init = 1'b1;
			end
			ACT_RSVD: begin
				rsp_d.status = ST_BAD_CTX;
			end
			ACT_LOCK, ACT_UNLOCK: begin
				if (!init_q) begin
					rsp_d.status = ST_NOT_INIT;
				end else if (bad_ctx) begin
					rsp_d.status = ST_BAD_CTX;
				end else if (action_t'(req_s1.action) == ACT_LOCK) begin
					if (!held_q) begin
						nxt_held = 1'b1;
						nxt_owner = req_s1.requester_task;
						nxt_wait = wait_q & ~me;
					end else if (owner_q == req_s1.requester_task) begin
						if ((wait_q & me) != '0) begin
							nxt_wait = wait_q & ~me;
						end else begin
							rsp_d.status = ST_RECURSIVE;
						end
					end else if (req_s1.irqs_were_off) begin
						rsp_d.status = ST_IRQS_OFF;
					end else begin
						nxt_wait = wait_q | me;
						rsp_d.status = ST_WAIT;
					end
				end else begin
					if (!held_q || owner_q != req_s1.requester_task) begin
						rsp_d.status = ST_NOT_OWNER;
					end else begin
						nxt_wait = wait_q & ~(stale & swept);
						if (found) begin
							nxt_owner = found_id;
							rsp_d.handoff_valid = 1'b1;
							rsp_d.handoff_task = found_id;
						end else begin
							nxt_held = 1'b0;
							nxt_owner = '0;
						end
					end
				end
			end
			default: begin
				rsp_d.status = ST_BAD_CTX;
			end
		endcase
		rsp_d.locked_after = nxt_held;
		rsp_d.owner_after = nxt_held ? nxt_owner : 5'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q <= 6'(MAX_TASKS);
			idle_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_NUM_TASKS: num_tasks_q <= cfg_data;
				CFG_IDLE_TASK: idle_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_t'(s_tdata[IN_BITS-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			held_q <= 1'b0;
			owner_q <= '0;
			wait_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				init_q <= nxt_init;
				held_q <= nxt_held;
				owner_q <= nxt_owner;
				wait_q <= nxt_wait;
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

endmodule
